// ===== rtl/dasf_pkg.sv =====
// ----------------------------------------------------------------------------
// dasf_pkg
// Shared types and constants for the delta arm step follower.
// ----------------------------------------------------------------------------
`default_nettype none

package dasf_pkg;

    localparam int ARMS       = 3;
    localparam int AXIS_W     = 2;
    localparam int STEP_W     = 10;
    localparam int OP_W       = 2;
    localparam int CFG_W      = 23;
    localparam int CFG_ADDR_W = 1;
    localparam int LSQ_W      = 2 * CFG_W;
    localparam int SQ_W       = 64;
    localparam int MAG_W      = 32;
    localparam int M_DATA_W   = 40;
    localparam int M_PAD_W    = M_DATA_W - 2 * ARMS - ARMS * STEP_W;

    // sqrt(3)/2 in Q0.16
    localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;
    localparam logic [SQ_W-1:0] MAG_CAP    = 64'h0000_0000_8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_FOLLOW = 2'd1,
        OP_PRESET = 2'd2
    } dasf_op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FOREARM = 1'b0,
        CFG_OFFSET  = 1'b1
    } dasf_cfg_t;

    typedef struct packed {
        logic above;   // distance^2 > L^2
        logic below;   // distance^2 < L^2
    } dasf_err_t;

endpackage

`default_nettype wire

// ===== rtl/dasf_elbow_mem.sv =====
// ----------------------------------------------------------------------------
// dasf_elbow_mem
// Elbow position table of one arm: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dasf_elbow_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 72
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/dasf_arm_err.sv =====
// ----------------------------------------------------------------------------
// dasf_arm_err
// One arm: joint point offset, squared distance to the elbow, sign vs L^2.
// Point registered at accept, squares registered, sum and compare after.
// ----------------------------------------------------------------------------
`default_nettype none

module dasf_arm_err import dasf_pkg::*; #(
    parameter int ARM_SEL     = 0,
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          pt_load,
    input  wire logic                          adv,
    input  wire logic signed [COORD_WIDTH-1:0] x_in,
    input  wire logic signed [COORD_WIDTH-1:0] y_in,
    input  wire logic signed [COORD_WIDTH-1:0] z_in,
    input  wire logic [CFG_W-1:0]              r_off,
    input  wire logic [CFG_W-1:0]              s_off,
    input  wire logic [CFG_W-1:0]              h_off,
    input  wire logic [3*COORD_WIDTH-1:0]      elbow,
    input  wire logic [LSQ_W-1:0]              lsq,
    output      dasf_err_t                     err
);

    localparam int PW = ((COORD_WIDTH > CFG_W + 1) ? COORD_WIDTH : CFG_W + 1) + 1;
    localparam int DW = PW + 1;

    logic signed [PW-1:0]          r_s, s_s, h_s;
    logic signed [PW-1:0]          px_next, py_next, px_reg, py_reg;
    logic signed [COORD_WIDTH-1:0] pz_reg;
    logic signed [COORD_WIDTH-1:0] ex, ey, ez;
    logic signed [DW-1:0]          diff [3];
    logic [DW-1:0]                 mag [3];
    logic [MAG_W-1:0]              capped [3];
    logic [SQ_W-1:0]               sq_next [3];
    logic [SQ_W-1:0]               sq_reg [3];
    logic [SQ_W-1:0]               sum;

    assign r_s = PW'($signed({1'b0, r_off}));
    assign s_s = PW'($signed({1'b0, s_off}));
    assign h_s = PW'($signed({1'b0, h_off}));

    always_comb begin
        px_next = PW'(x_in);
        py_next = PW'(y_in);
        case (ARM_SEL)
            0: begin
                py_next = PW'(y_in) + r_s;
            end
            1: begin
                px_next = PW'(x_in) - s_s;
                py_next = PW'(y_in) - h_s;
            end
            default: begin
                px_next = PW'(x_in) + s_s;
                py_next = PW'(y_in) - h_s;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pt_load) begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= z_in;
        end
    end

    assign ex = elbow[0 +: COORD_WIDTH];
    assign ey = elbow[COORD_WIDTH +: COORD_WIDTH];
    assign ez = elbow[2*COORD_WIDTH +: COORD_WIDTH];

    always_comb begin
        diff[0] = DW'(ex) - DW'(px_reg);
        diff[1] = DW'(ey) - DW'(py_reg);
        diff[2] = DW'(ez) - DW'(pz_reg);
        for (int k = 0; k < 3; k++) begin
            mag[k]     = diff[k][DW-1] ? DW'(-diff[k]) : DW'(diff[k]);
            capped[k]  = (SQ_W'(mag[k]) > MAG_CAP) ? MAG_W'(MAG_CAP) : MAG_W'(mag[k]);
            sq_next[k] = SQ_W'(capped[k]) * SQ_W'(capped[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg <= sq_next;
        end
    end

    assign sum       = sq_reg[0] + sq_reg[1] + sq_reg[2];
    assign err.above = sum > SQ_W'(lsq);
    assign err.below = sum < SQ_W'(lsq);

endmodule

`default_nettype wire

// ===== rtl/delta_arm_step_follower.sv =====
// ----------------------------------------------------------------------------
// delta_arm_step_follower
// Three-arm delta robot step follower: elbow tables, target and motor steps.
//
//   channel | dir | handshake          | content
//   --------+-----+--------------------+-------------------------------------
//   cfg     | in  | cfg_wr_en          | forearm_length, effector_offset
//   s_      | in  | s_tvalid/s_tready  | opcode; axis, index, x, y, z
//   m_      | out | m_tvalid/m_tready  | step/dir masks, three target steps
//
// An input beat passes the first-stage registers, the second-stage registers
// and the result register. Load and unknown-opcode beats flow one per cycle
// while the result register is not stalled; a follow or preset beat in the
// first stage holds off the next input beat (the table read address takes
// the target step bypassed from the compare stage).
// A stalled result register freezes all stages. No clearing pass: table
// entries are undefined until loaded; steps and registers reset to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_arm_step_follower import dasf_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [CFG_W-1:0]            cfg_wdata,
    input  wire logic                        s_tvalid,
    output      logic                        s_tready,
    // axis, index, x_coord, y_coord, z_coord, zero pad
    input  wire logic [((AXIS_W+STEP_W+3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // opcode
    input  wire logic [OP_W-1:0]             s_tuser,
    output      logic                        m_tvalid,
    input  wire logic                        m_tready,
    // step_mask, dir_mask, target_step_a, target_step_b, target_step_c, zero pad
    output      logic [M_DATA_W-1:0]         m_tdata
);

    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int ELB_W    = 3 * COORD_WIDTH;
    localparam int X_LSB    = AXIS_W + STEP_W;
    localparam int W1       = STEP_W + 1;
    localparam int LIMIT_I  = ((TABLE_DEPTH < (1 << STEP_W)) ? TABLE_DEPTH : (1 << STEP_W)) - 1;
    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(LIMIT_I);

    logic [CFG_W-1:0]  forearm_reg, offset_reg, s_off_reg, h_off_reg;
    logic [LSQ_W-1:0]  lsq_reg;

    dasf_op_t                    in_op;
    logic [AXIS_W-1:0]           in_axis;
    logic [STEP_W-1:0]           in_index;
    logic signed [COORD_WIDTH-1:0] in_x, in_y, in_z;
    logic                        accept, advance, hold, load_ok;

    logic                        s1_valid_reg, s2_valid_reg;
    dasf_op_t                    s1_op_reg, s2_op_reg;
    logic [AXIS_W-1:0]           s1_axis_reg, s2_axis_reg;
    logic [STEP_W-1:0]           s1_index_reg, s2_index_reg;

    logic [STEP_W-1:0]           target_reg [ARMS];
    logic [STEP_W-1:0]           motor_reg [ARMS];
    logic [STEP_W-1:0]           target_next [ARMS];
    logic [STEP_W-1:0]           motor_next [ARMS];
    logic [ARMS-1:0]             step_next, dir_next;
    dasf_err_t                   arm_err [ARMS];

    logic                        m_valid_reg;
    logic [ARMS-1:0]             m_step_reg, m_dir_reg;
    logic [STEP_W-1:0]           out_tgt_reg [ARMS];

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forearm_reg <= '0;
            offset_reg  <= '0;
            s_off_reg   <= '0;
            h_off_reg   <= '0;
            lsq_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (dasf_cfg_t'(cfg_addr))
                    CFG_FOREARM: forearm_reg <= cfg_wdata;
                    CFG_OFFSET: begin
                        offset_reg <= cfg_wdata;
                        s_off_reg  <= CFG_W'((40'(cfg_wdata) * 40'(SQRT3_HALF_Q16)
                                              + 40'd32768) >> 16);
                        h_off_reg  <= CFG_W'((24'(cfg_wdata) + 24'd1) >> 1);
                    end
                    default: ;
                endcase
            end
            lsq_reg   <= LSQ_W'(forearm_reg) * LSQ_W'(forearm_reg);
        end
    end

    // ---------------- input side ----------------
    assign in_op    = dasf_op_t'(s_tuser);
    assign in_axis  = s_tdata[AXIS_W-1:0];
    assign in_index = s_tdata[AXIS_W +: STEP_W];
    assign in_x     = s_tdata[X_LSB +: COORD_WIDTH];
    assign in_y     = s_tdata[X_LSB + COORD_WIDTH +: COORD_WIDTH];
    assign in_z     = s_tdata[X_LSB + 2*COORD_WIDTH +: COORD_WIDTH];
    assign load_ok  = 32'(in_index) < 32'(TABLE_DEPTH);

    assign advance  = !m_valid_reg || m_tready;
    assign hold     = s1_valid_reg && (s1_op_reg == OP_FOLLOW || s1_op_reg == OP_PRESET);
    assign s_tready = aresetn && advance && !hold;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg    <= in_op;
            s1_axis_reg  <= in_axis;
            s1_index_reg <= in_index;
        end
        if (advance) begin
            s2_op_reg    <= s1_op_reg;
            s2_axis_reg  <= s1_axis_reg;
            s2_index_reg <= s1_index_reg;
        end
    end

    // ---------------- per-arm tables and error ----------------
    for (genvar k = 0; k < ARMS; k++) begin : g_arm
        logic [ELB_W-1:0] elbow;

        dasf_elbow_mem #(
            .DEPTH (TABLE_DEPTH),
            .WIDTH (ELB_W)
        ) u_mem (
            .aclk    (aclk),
            .wr_en   (accept && in_op == OP_LOAD && in_axis == AXIS_W'(k) && load_ok),
            .wr_addr (ADDR_W'(in_index)),
            .wr_data ({in_z, in_y, in_x}),
            .rd_en   (accept && in_op == OP_FOLLOW),
            .rd_addr (ADDR_W'(target_next[k])),
            .rd_data (elbow)
        );

        dasf_arm_err #(
            .ARM_SEL     (k),
            .COORD_WIDTH (COORD_WIDTH)
        ) u_err (
            .aclk    (aclk),
            .pt_load (accept),
            .adv     (advance),
            .x_in    (in_x),
            .y_in    (in_y),
            .z_in    (in_z),
            .r_off   (offset_reg),
            .s_off   (s_off_reg),
            .h_off   (h_off_reg),
            .elbow   (elbow),
            .lsq     (lsq_reg),
            .err     (arm_err[k])
        );
    end

    // ---------------- step update ----------------
    always_comb begin
        logic [STEP_W-1:0] t_cur;
        logic [STEP_W-1:0] p_val;
        t_cur     = '0;
        p_val     = (s2_index_reg > STEP_LIMIT) ? STEP_LIMIT : s2_index_reg;
        step_next = '0;
        dir_next  = '0;
        for (int a = 0; a < ARMS; a++) begin
            target_next[a] = target_reg[a];
            motor_next[a]  = motor_reg[a];
        end
        if (advance && s2_valid_reg) begin
            case (s2_op_reg)
                OP_FOLLOW: begin
                    for (int a = 0; a < ARMS; a++) begin
                        t_cur = target_reg[a];
                        if (arm_err[a].above && t_cur < STEP_LIMIT) begin
                            t_cur = t_cur + 1'b1;
                        end else if (arm_err[a].below && t_cur != '0) begin
                            t_cur = t_cur - 1'b1;
                        end
                        target_next[a] = t_cur;
                        if ({1'b0, t_cur} > {1'b0, motor_reg[a]} + W1'(1)) begin
                            motor_next[a] = motor_reg[a] + 1'b1;
                            step_next[a]  = 1'b1;
                            dir_next[a]   = 1'b1;
                        end else if ({1'b0, motor_reg[a]} > {1'b0, t_cur} + W1'(1)) begin
                            motor_next[a] = motor_reg[a] - 1'b1;
                            step_next[a]  = 1'b1;
                        end
                    end
                end
                OP_PRESET: begin
                    for (int a = 0; a < ARMS; a++) begin
                        if (s2_axis_reg == AXIS_W'(a)) begin
                            target_next[a] = p_val;
                            motor_next[a]  = p_val;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < ARMS; a++) begin
                target_reg[a] <= '0;
                motor_reg[a]  <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            target_reg <= target_next;
            motor_reg  <= motor_next;
            if (advance) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s2_valid_reg) begin
            m_step_reg  <= step_next;
            m_dir_reg   <= dir_next;
            out_tgt_reg <= target_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), out_tgt_reg[2], out_tgt_reg[1], out_tgt_reg[0],
                       m_dir_reg, m_step_reg};

    // ---------------- assertions ----------------
    for (genvar g = 0; g < ARMS; g++) begin : g_chk
        assert property (@(posedge aclk) disable iff (!aresetn)
            (W1'(target_reg[g]) <= W1'(motor_reg[g]) + W1'(1)) &&
            (W1'(motor_reg[g]) <= W1'(target_reg[g]) + W1'(1)))
        else $error("motor step drifted more than one from target");

        assert property (@(posedge aclk) disable iff (!aresetn)
            target_reg[g] <= STEP_LIMIT)
        else $error("target step beyond table end");
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_dir_reg & ~m_step_reg) == '0))
    else $error("direction bit without step pulse");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && s2_valid_reg && s2_op_reg != OP_FOLLOW) |=> (m_step_reg == '0))
    else $error("step pulse from a non-follow beat");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for delta_arm_step_follower. Loads, presets and
// follow points are generated alongside a behavioral model of the three arm
// step counts. Each expected report is queued when its command is queued.
// The result stream is checked beat by beat against that queue, with random
// idle gaps on both sides. Register settings change only between phases,
// once the block has drained.
// ----------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dasf_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int CW        = 24;
    localparam int STEP_MAX  = 1023;
    localparam int S_DATA_W  = ((AXIS_W + STEP_W + 3 * CW + 7) / 8) * 8;
    localparam int AXIS_NONE = 3;
    localparam int MAXC      = 8388607;
    localparam int MINC      = -8388608;
    localparam int MAX_REG   = 8388607;
    localparam longint SIN60_Q16 = 56756;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [AXIS_W-1:0]    axis;
        logic [STEP_W-1:0]    index;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cmd_t;

    typedef struct {
        logic [2:0]        step_mask;
        logic [2:0]        dir_mask;
        logic [STEP_W-1:0] tgt_a;
        logic [STEP_W-1:0] tgt_b;
        logic [STEP_W-1:0] tgt_c;
    } report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // axis, index, x_coord, y_coord, z_coord, zero pad
    logic [S_DATA_W-1:0]   s_tdata = '0;
    // opcode
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // step_mask, dir_mask, target_step_a, target_step_b, target_step_c, zero pad
    logic [M_DATA_W-1:0]   m_tdata;

    delta_arm_step_follower #(
        .TABLE_DEPTH(DEPTH),
        .COORD_WIDTH(CW)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // arm model state
    logic signed [CW-1:0] elb_x [ARMS][DEPTH];
    logic signed [CW-1:0] elb_y [ARMS][DEPTH];
    logic signed [CW-1:0] elb_z [ARMS][DEPTH];
    bit                   loaded [ARMS][DEPTH];
    int                   tgt [ARMS];
    int                   mot [ARMS];
    int unsigned          forearm_q;
    int unsigned          offset_q;

    cmd_t    cmd_queue[$];
    report_t step_reports[$];
    int      bad_beats = 0;
    int      sent_items = 0;
    int      src_gap = 0;
    int      sink_gap = 0;
    bit      idle_en = 1'b1;

    function automatic longint unsigned sq_cap(longint d);
        longint unsigned m;
        m = (d < 0) ? -d : d;
        if (m > 64'h8000_0000)
            m = 64'h8000_0000;
        return m * m;
    endfunction

    function automatic int dist_sign(int a, longint px, longint py, longint pz);
        longint r, s, h, bx, by, f;
        longint unsigned sum, lsq;
        r = longint'(offset_q);
        f = longint'(forearm_q);
        s = (r * SIN60_Q16 + 32768) >>> 16;
        h = (r + 1) >>> 1;
        bx = px;
        by = py;
        case (a)
            0: by = py + r;
            1: begin
                bx = px - s;
                by = py - h;
            end
            default: begin
                bx = px + s;
                by = py - h;
            end
        endcase
        sum = sq_cap(longint'(elb_x[a][tgt[a]]) - bx)
            + sq_cap(longint'(elb_y[a][tgt[a]]) - by)
            + sq_cap(longint'(elb_z[a][tgt[a]]) - pz);
        lsq = f * f;
        if (sum > lsq) return 1;
        if (sum < lsq) return -1;
        return 0;
    endfunction

    function automatic report_t advance_arms(cmd_t c);
        report_t rep;
        int sg;
        int a;
        rep.step_mask = '0;
        rep.dir_mask = '0;
        case (c.op)
            OP_LOAD: begin
                if (c.axis != AXIS_NONE) begin
                    elb_x[c.axis][c.index] = c.x;
                    elb_y[c.axis][c.index] = c.y;
                    elb_z[c.axis][c.index] = c.z;
                    loaded[c.axis][c.index] = 1'b1;
                end
            end
            OP_PRESET: begin
                if (c.axis != AXIS_NONE) begin
                    tgt[c.axis] = (c.index > STEP_MAX) ? STEP_MAX : int'(c.index);
                    mot[c.axis] = tgt[c.axis];
                end
            end
            OP_FOLLOW: begin
                for (a = 0; a < ARMS; a++) begin
                    sg = dist_sign(a, longint'(c.x), longint'(c.y), longint'(c.z));
                    if (sg > 0 && tgt[a] < STEP_MAX)
                        tgt[a]++;
                    else if (sg < 0 && tgt[a] > 0)
                        tgt[a]--;
                    if (tgt[a] > mot[a] + 1) begin
                        mot[a]++;
                        rep.step_mask[a] = 1'b1;
                        rep.dir_mask[a] = 1'b1;
                    end else if (mot[a] > tgt[a] + 1) begin
                        mot[a]--;
                        rep.step_mask[a] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        rep.tgt_a = STEP_W'(tgt[0]);
        rep.tgt_b = STEP_W'(tgt[1]);
        rep.tgt_c = STEP_W'(tgt[2]);
        return rep;
    endfunction

    function automatic cmd_t mk(logic [OP_W-1:0] op, int axis, int index,
                                int x, int y, int z);
        cmd_t c;
        c.op = op;
        c.axis = AXIS_W'(axis);
        c.index = STEP_W'(index);
        c.x = CW'(x);
        c.y = CW'(y);
        c.z = CW'(z);
        return c;
    endfunction

    function automatic int full_coord();
        return int'($urandom_range(0, 24'hFFFFFF)) + MINC;
    endfunction

    function automatic int rand_coord(int span);
        if (span >= MAXC)
            return full_coord();
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send(cmd_t c);
        cmd_queue.push_back(c);
        step_reports.push_back(advance_arms(c));
        sent_items++;
    endtask

    // never read an elbow entry that was not loaded
    task automatic send_follow(int x, int y, int z, int span);
        int a;
        for (a = 0; a < ARMS; a++)
            if (!loaded[a][tgt[a]])
                send(mk(OP_LOAD, a, tgt[a], rand_coord(span), rand_coord(span),
                        rand_coord(span)));
        send(mk(OP_FOLLOW, 0, 0, x, y, z));
    endtask

    task automatic send_preset_all(int idx);
        int a;
        for (a = 0; a < ARMS; a++)
            send(mk(OP_PRESET, a, idx, 0, 0, 0));
    endtask

    task automatic write_reg(dasf_cfg_t which, int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= which;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (which == CFG_FOREARM)
            forearm_q = val;
        else
            offset_q = val;
    endtask

    task automatic set_regs(int unsigned len, int unsigned ofs);
        write_reg(CFG_FOREARM, len);
        write_reg(CFG_OFFSET, ofs);
    endtask

    task automatic drain();
        while (cmd_queue.size() != 0 || step_reports.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                void'(cmd_queue.pop_front());
                src_gap = draw_gap();
            end
            if (s_tvalid && !s_tready) begin
                // hold the beat
            end else if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= cmd_queue[0].op;
                s_tdata <= {{(S_DATA_W - AXIS_W - STEP_W - 3 * CW){1'b0}},
                            cmd_queue[0].z, cmd_queue[0].y, cmd_queue[0].x,
                            cmd_queue[0].index, cmd_queue[0].axis};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge aclk) begin : mon
        report_t w;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (step_reports.size() == 0) begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("unexpected result beat: %h", m_tdata);
                end else begin
                    w = step_reports.pop_front();
                    if (m_tdata[2:0] !== w.step_mask || m_tdata[5:3] !== w.dir_mask ||
                        m_tdata[15:6] !== w.tgt_a || m_tdata[25:16] !== w.tgt_b ||
                        m_tdata[35:26] !== w.tgt_c) begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display("mismatch: exp step=%b dir=%b tgt=%0d/%0d/%0d, %s",
                                     w.step_mask, w.dir_mask, w.tgt_a, w.tgt_b, w.tgt_c,
                                     $sformatf("got step=%b dir=%b tgt=%0d/%0d/%0d",
                                               m_tdata[2:0], m_tdata[5:3], m_tdata[15:6],
                                               m_tdata[25:16], m_tdata[35:26]));
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_gap = draw_gap();
            end
        end
    end

    initial begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        int unsigned ph_len [6];
        int unsigned ph_ofs [6];
        int p, n, a, idx, span, roll, ph_start;
        logic [OP_W-1:0] op;
        int ax;

        forearm_q = 0;
        offset_q = 0;
        for (a = 0; a < ARMS; a++) begin
            tgt[a] = 0;
            mot[a] = 0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero error, ignored beats, table ends
        set_regs(256, 0);
        for (a = 0; a < ARMS; a++)
            send(mk(OP_LOAD, a, 0, 256, 0, 0));
        send_follow(0, 0, 0, 256);
        send(mk(OP_LOAD, AXIS_NONE, 5, MAXC, MAXC, MAXC));
        send(mk(OP_LOAD, 0, STEP_MAX, MINC, MINC, MINC));
        send(mk(OP_LOAD, 1, STEP_MAX, MAXC, MAXC, MAXC));
        send(mk(OP_LOAD, 2, STEP_MAX, MAXC, MINC, 0));
        send(mk(OP_PRESET, AXIS_NONE, 7, 0, 0, 0));
        send(mk(OP_UNKNOWN, 1, STEP_MAX, MAXC, MINC, MAXC));
        send_preset_all(STEP_MAX);
        send_follow(MAXC, MAXC, MAXC, 256);
        send_preset_all(0);
        send_follow(256, 0, 0, 256);
        drain();

        // zero length: target advances on every follow, motor steps forward
        set_regs(0, 0);
        send_preset_all(0);
        repeat (5) send_follow(0, 0, 0, 4096);
        drain();

        // longest forearm: backward steps
        set_regs(MAX_REG, 0);
        send_preset_all(500);
        repeat (5) send_follow(0, 0, 0, 4096);
        drain();

        ph_len[0] = 0;       ph_ofs[0] = MAX_REG;
        ph_len[1] = MAX_REG; ph_ofs[1] = MAX_REG;
        ph_len[2] = 4096;    ph_ofs[2] = 100;
        for (p = 3; p < 6; p++) begin
            ph_len[p] = $urandom_range(1, 1 << $urandom_range(4, 22));
            ph_ofs[p] = $urandom_range(0, ph_len[p] / 2);
        end

        for (p = 0; p < 6; p++) begin
            set_regs(ph_len[p], ph_ofs[p]);
            span = (ph_len[p] == 0) ? 4096 : ph_len[p];
            idle_en = (p != 2);
            n = 0;
            ph_start = sent_items;
            while (sent_items - ph_start < 175) begin
                if (n % 50 == 49)
                    idle_en = ($urandom_range(0, 3) != 0);
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    op = OP_W'($urandom_range(0, 3));
                    if (op == OP_FOLLOW) begin
                        send_follow(full_coord(), full_coord(), full_coord(), span);
                        n++;
                    end else begin
                        ax = $urandom_range(0, 3);
                        send(mk(op, ax, $urandom_range(0, STEP_MAX), full_coord(),
                                full_coord(), full_coord()));
                        if (op != OP_UNKNOWN && ax != AXIS_NONE)
                            n++;
                    end
                end else if (roll < 20) begin
                    a = $urandom_range(0, 2);
                    if (roll < 14)
                        idx = tgt[a] + int'($urandom_range(0, 8)) - 4;
                    else
                        idx = $urandom_range(0, STEP_MAX);
                    if (idx < 0) idx = 0;
                    if (idx > STEP_MAX) idx = STEP_MAX;
                    send(mk(OP_LOAD, a, idx, rand_coord(span), rand_coord(span),
                            rand_coord(span)));
                    n++;
                end else if (roll < 26) begin
                    a = $urandom_range(0, 2);
                    case ($urandom_range(0, 3))
                        0: idx = 0;
                        1: idx = STEP_MAX;
                        default: idx = $urandom_range(0, STEP_MAX);
                    endcase
                    send(mk(OP_PRESET, a, idx, 0, 0, 0));
                    n++;
                end else begin
                    send_follow(rand_coord(span / 4), rand_coord(span / 4),
                                rand_coord(span / 4), span);
                    n++;
                end
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (bad_beats == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dasf_pkg.sv
rtl/dasf_elbow_mem.sv
rtl/dasf_arm_err.sv
rtl/delta_arm_step_follower.sv
verif/testbench.sv
